>>> hw/rtl/wav_header_parser_assert.svh
// Assertion macros used by the checker file of the WAV header parser.
`ifndef WAV_HEADER_PARSER_ASSERT_SVH
`define WAV_HEADER_PARSER_ASSERT_SVH

// Check a property on every clock edge outside of reset.
`define WHP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("wav header parser check failed");

// Check a property on every clock edge, reset included.
`define WHP_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("wav header parser check failed");

`endif

>>> hw/rtl/whp_pkg.sv
package whp_pkg;

   // Chunk tags as they appear in a little-endian 32-bit word
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   // fmt chunk sizes and the accepted sample format
   localparam logic [31:0] FMT_MIN_SIZE  = 32'd16;
   localparam logic [31:0] FMT_EXT_SIZE  = 32'd18;
   localparam logic [15:0] PCM_FORMAT    = 16'd1;
   localparam logic [15:0] PCM_BITS      = 16'd16;
   localparam logic [15:0] CH_MONO       = 16'd1;
   localparam logic [15:0] CH_STEREO     = 16'd2;

   // Status codes of a result
   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_NO_RIFF   = 4'd1;
   localparam logic [3:0] ST_NO_WAVE   = 4'd2;
   localparam logic [3:0] ST_NO_FMT    = 4'd3;
   localparam logic [3:0] ST_FMT_SHORT = 4'd4;
   localparam logic [3:0] ST_TRUNC     = 4'd5;
   localparam logic [3:0] ST_TOO_BIG   = 4'd6;
   localparam logic [3:0] ST_NOT_PCM   = 4'd7;
   localparam logic [3:0] ST_BAD_CH    = 4'd8;
   localparam logic [3:0] ST_BAD_BITS  = 4'd9;
   localparam logic [3:0] ST_LAST      = ST_BAD_BITS;

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RIFF_HDR,
      PH_WAVE,
      PH_FMT_HDR,
      PH_FORMAT,
      PH_CHANNELS,
      PH_RATE,
      PH_BYTE_RATE,
      PH_ALIGN,
      PH_BITS,
      PH_EXTRA_CNT,
      PH_EXTRA_SKP,
      PH_CHUNK_HDR,
      PH_CHUNK_SKP
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_of_file;
      logic       end_of_file;
   } req_item_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] audio_format;
      logic [15:0] channels;
      logic [31:0] sample_rate;
      logic [31:0] byte_rate;
      logic [15:0] frame_bytes;
      logic [15:0] bits_per_sample;
      logic [31:0] data_size;
      logic [31:0] data_offset;
   } rsp_item_type;

   // Head of the request queue as the back end sees it
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } queue_head_type;

endpackage

>>> hw/rtl/whp_req_if.sv
interface whp_req_if
   import whp_pkg::*;
   ();
   logic         valid;
   logic         ready;
   req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

>>> hw/rtl/whp_rsp_if.sv
interface whp_rsp_if
   import whp_pkg::*;
   ();
   logic         valid;
   logic         ready;
   rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

>>> hw/rtl/wav_header_parser.sv
// WAV header parser: takes a WAV file as a byte stream, one byte per request,
// with first_of_file restarting the parse and end_of_file marking the last
// byte. It checks the RIFF, WAVE and fmt tags, captures the fmt fields, skips
// the fmt extra bytes and any chunk ahead of the data chunk, and gives one
// response per file carrying a status code, the fmt fields, the data size and
// the byte offset of the first sample. Bytes outside a file (before the first
// first_of_file, or after the response until the next first_of_file) are
// taken and dropped. Throughput is one byte per clock: a two-entry request
// queue feeds the parser, and the response sits in an output register. The
// parser stalls only while that register holds a response not yet taken;
// the deciding byte of a response passes through the request queue, and
// the response is then loaded into the output register.
module wav_header_parser
   import whp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   whp_req_if.sink   req_ch,
   whp_rsp_if.source rsp_ch
);

   queue_head_type head;
   logic           pop;

   whp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_item  (req_ch.item),
      .req_ready (req_ch.ready),
      .pop       (pop),
      .head      (head)
   );

   whp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_item  (rsp_ch.item)
   );

endmodule

>>> hw/rtl/whp_front.sv
module whp_front
   import whp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  req_item_type   req_item,
   output logic           req_ready,
   input  logic           pop,
   output queue_head_type head
);

   req_item_type           q_mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push;

   // Accept a request whenever a slot is free
   assign req_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;

   // Present the oldest request to the back end
   assign head.valid = (count_ff != '0);
   assign head.item  = q_mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? QUEUE_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QUEUE_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QUEUE_CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QUEUE_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming request
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

>>> hw/rtl/whp_back.sv
module whp_back
   import whp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   output rsp_item_type   rsp_item
);

   phase_type    phase_ff, phase_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic [31:0]  tag_ff, tag_in;
   logic [31:0]  size_ff, size_in;
   logic [31:0]  riff_ff, riff_in;
   logic [31:0]  fmt_size_ff, fmt_size_in;
   logic [31:0]  skip_ff, skip_in;
   logic [31:0]  pos_ff, pos_in;
   logic [15:0]  format_ff, format_in;
   logic [15:0]  channels_ff, channels_in;
   logic [31:0]  rate_ff, rate_in;
   logic [31:0]  brate_ff, brate_in;
   logic [15:0]  align_ff, align_in;
   logic [15:0]  bits_ff, bits_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   // Current view of the state: a first byte starts from a cleared state
   logic         first;
   phase_type    cur_phase;
   logic [2:0]   cur_cnt;
   logic [31:0]  cur_tag, cur_size, cur_riff, cur_fmt_size, cur_skip, cur_pos;
   logic [15:0]  cur_format, cur_channels, cur_align, cur_bits;
   logic [31:0]  cur_rate, cur_brate;

   logic [31:0]  shift_word;
   logic [31:0]  tag_shift;
   logic [2:0]   cnt_inc;
   logic [31:0]  skip_dec;
   logic         hdr_done;
   logic         field_done;
   logic         wide_field;

   // Control outputs of the phase logic
   logic         emit;
   logic         found;
   logic [3:0]   status;
   logic         tag_en, size_en, pos_en;
   logic         ld_riff, ld_fmt, ld_format, ld_channels, ld_rate, ld_brate;
   logic         ld_align, ld_bits, ld_skip_size, ld_skip_extra, dec_skip;

   // Take the next request when the result register can hold what it gives
   assign pop = head.valid && (!rsp_valid_ff || rsp_ready);
   assign first = head.item.first_of_file;

   always_comb begin
      cur_phase    = first ? PH_RIFF_HDR : phase_ff;
      cur_cnt      = first ? '0 : cnt_ff;
      cur_tag      = first ? '0 : tag_ff;
      cur_size     = first ? '0 : size_ff;
      cur_riff     = first ? '0 : riff_ff;
      cur_fmt_size = first ? '0 : fmt_size_ff;
      cur_skip     = first ? '0 : skip_ff;
      cur_pos      = first ? '0 : pos_ff;
      cur_format   = first ? '0 : format_ff;
      cur_channels = first ? '0 : channels_ff;
      cur_rate     = first ? '0 : rate_ff;
      cur_brate    = first ? '0 : brate_ff;
      cur_align    = first ? '0 : align_ff;
      cur_bits     = first ? '0 : bits_ff;
   end

   // Shift the byte into the tag and size words
   assign shift_word = {head.item.data_byte, cur_size[31:8]};
   assign tag_shift  = {head.item.data_byte, cur_tag[31:8]};
   assign cnt_inc    = cur_cnt + 3'd1;
   assign skip_dec   = cur_skip - 32'd1;
   assign hdr_done   = (cur_cnt == 3'd7);
   assign wide_field = (cur_phase == PH_WAVE) || (cur_phase == PH_RATE) ||
                       (cur_phase == PH_BYTE_RATE);
   assign field_done = wide_field ? (cnt_inc >= 3'd4) : (cnt_inc >= 3'd2);

   // Next phase, counter and result decision
   always_comb begin
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      emit          = 1'b0;
      found         = 1'b0;
      status        = ST_OK;
      tag_en        = 1'b0;
      size_en       = 1'b0;
      pos_en        = 1'b0;
      ld_riff       = 1'b0;
      ld_fmt        = 1'b0;
      ld_format     = 1'b0;
      ld_channels   = 1'b0;
      ld_rate       = 1'b0;
      ld_brate      = 1'b0;
      ld_align      = 1'b0;
      ld_bits       = 1'b0;
      ld_skip_size  = 1'b0;
      ld_skip_extra = 1'b0;
      dec_skip      = 1'b0;
      if (pop && (cur_phase != PH_IDLE)) begin
         pos_en   = 1'b1;
         phase_in = cur_phase;
         cnt_in   = cur_cnt;
         case (cur_phase)
            PH_RIFF_HDR, PH_FMT_HDR, PH_CHUNK_HDR: begin
               tag_en  = !cur_cnt[2];
               size_en = cur_cnt[2];
               cnt_in  = hdr_done ? 3'd0 : cnt_inc;
               if (hdr_done) begin
                  case (cur_phase)
                     PH_RIFF_HDR: begin
                        if (cur_tag != TAG_RIFF) begin
                           status = ST_NO_RIFF;
                           emit   = 1'b1;
                        end else begin
                           ld_riff  = 1'b1;
                           phase_in = PH_WAVE;
                        end
                     end
                     PH_FMT_HDR: begin
                        if (cur_tag != TAG_FMT) begin
                           status = ST_NO_FMT;
                           emit   = 1'b1;
                        end else if (shift_word < FMT_MIN_SIZE) begin
                           status = ST_FMT_SHORT;
                           emit   = 1'b1;
                        end else begin
                           ld_fmt   = 1'b1;
                           phase_in = PH_FORMAT;
                        end
                     end
                     default: begin
                        if (shift_word > cur_riff) begin
                           status = ST_TOO_BIG;
                           emit   = 1'b1;
                        end else if (cur_tag == TAG_DATA) begin
                           emit  = 1'b1;
                           found = 1'b1;
                           if (cur_format != PCM_FORMAT) begin
                              status = ST_NOT_PCM;
                           end else if (cur_channels != CH_MONO &&
                                        cur_channels != CH_STEREO) begin
                              status = ST_BAD_CH;
                           end else if (cur_bits != PCM_BITS) begin
                              status = ST_BAD_BITS;
                           end else begin
                              status = ST_OK;
                           end
                        end else begin
                           ld_skip_size = 1'b1;
                           phase_in = (shift_word != '0) ? PH_CHUNK_SKP : PH_CHUNK_HDR;
                        end
                     end
                  endcase
               end
            end
            PH_WAVE, PH_FORMAT, PH_CHANNELS, PH_RATE, PH_BYTE_RATE, PH_ALIGN,
            PH_BITS, PH_EXTRA_CNT: begin
               size_en = 1'b1;
               cnt_in  = field_done ? 3'd0 : cnt_inc;
               if (field_done) begin
                  case (cur_phase)
                     PH_WAVE: begin
                        if (shift_word != TAG_WAVE) begin
                           status = ST_NO_WAVE;
                           emit   = 1'b1;
                        end else begin
                           phase_in = PH_FMT_HDR;
                        end
                     end
                     PH_FORMAT: begin
                        ld_format = 1'b1;
                        phase_in  = PH_CHANNELS;
                     end
                     PH_CHANNELS: begin
                        ld_channels = 1'b1;
                        phase_in    = PH_RATE;
                     end
                     PH_RATE: begin
                        ld_rate  = 1'b1;
                        phase_in = PH_BYTE_RATE;
                     end
                     PH_BYTE_RATE: begin
                        ld_brate = 1'b1;
                        phase_in = PH_ALIGN;
                     end
                     PH_ALIGN: begin
                        ld_align = 1'b1;
                        phase_in = PH_BITS;
                     end
                     PH_BITS: begin
                        ld_bits  = 1'b1;
                        phase_in = (cur_fmt_size >= FMT_EXT_SIZE) ? PH_EXTRA_CNT
                                                                  : PH_CHUNK_HDR;
                     end
                     default: begin
                        ld_skip_extra = 1'b1;
                        phase_in = (shift_word[31:16] != '0) ? PH_EXTRA_SKP
                                                             : PH_CHUNK_HDR;
                     end
                  endcase
               end
            end
            PH_EXTRA_SKP, PH_CHUNK_SKP: begin
               dec_skip = 1'b1;
               if (skip_dec == '0) begin
                  phase_in = PH_CHUNK_HDR;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
         // Report truncation when the file ends before a decision
         if (!emit && head.item.end_of_file && phase_in != PH_IDLE) begin
            status = ST_TRUNC;
            emit   = 1'b1;
         end
         if (emit) begin
            phase_in = PH_IDLE;
         end
      end
   end

   // Update the data path registers
   always_comb begin
      tag_in      = pop ? cur_tag : tag_ff;
      size_in     = pop ? cur_size : size_ff;
      riff_in     = pop ? cur_riff : riff_ff;
      fmt_size_in = pop ? cur_fmt_size : fmt_size_ff;
      skip_in     = pop ? cur_skip : skip_ff;
      pos_in      = pop ? cur_pos : pos_ff;
      format_in   = pop ? cur_format : format_ff;
      channels_in = pop ? cur_channels : channels_ff;
      rate_in     = pop ? cur_rate : rate_ff;
      brate_in    = pop ? cur_brate : brate_ff;
      align_in    = pop ? cur_align : align_ff;
      bits_in     = pop ? cur_bits : bits_ff;
      if (tag_en) begin
         tag_in = tag_shift;
      end
      if (size_en) begin
         size_in = shift_word;
      end
      if (pos_en) begin
         pos_in = cur_pos + 32'd1;
      end
      if (ld_riff) begin
         riff_in = shift_word;
      end
      if (ld_fmt) begin
         fmt_size_in = shift_word;
      end
      if (ld_format) begin
         format_in = shift_word[31:16];
      end
      if (ld_channels) begin
         channels_in = shift_word[31:16];
      end
      if (ld_rate) begin
         rate_in = shift_word;
      end
      if (ld_brate) begin
         brate_in = shift_word;
      end
      if (ld_align) begin
         align_in = shift_word[31:16];
      end
      if (ld_bits) begin
         bits_in = shift_word[31:16];
      end
      if (ld_skip_size) begin
         skip_in = shift_word;
      end else if (ld_skip_extra) begin
         skip_in = {16'd0, shift_word[31:16]};
      end else if (dec_skip) begin
         skip_in = skip_dec;
      end
   end

   // Load the result register, drop it once taken
   always_comb begin
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in                = 1'b1;
         rsp_item_in.status          = status;
         rsp_item_in.audio_format    = format_in;
         rsp_item_in.channels        = channels_in;
         rsp_item_in.sample_rate     = rate_in;
         rsp_item_in.byte_rate       = brate_in;
         rsp_item_in.frame_bytes     = align_in;
         rsp_item_in.bits_per_sample = bits_in;
         rsp_item_in.data_size       = found ? shift_word : '0;
         rsp_item_in.data_offset     = found ? pos_in : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff      <= tag_in;
      size_ff     <= size_in;
      riff_ff     <= riff_in;
      fmt_size_ff <= fmt_size_in;
      skip_ff     <= skip_in;
      pos_ff      <= pos_in;
      format_ff   <= format_in;
      channels_ff <= channels_in;
      rate_ff     <= rate_in;
      brate_ff    <= brate_in;
      align_ff    <= align_in;
      bits_ff     <= bits_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

>>> hw/rtl/whp_checker.sv
`include "wav_header_parser_assert.svh"

module whp_checker
   import whp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_item
);

   logic no_data_status;
   logic data_zero;
   logic pcm_good;

   // Classify the response fields for the checks below
   assign no_data_status = rsp_item.status inside {ST_NO_RIFF, ST_NO_WAVE, ST_NO_FMT,
                                                   ST_FMT_SHORT, ST_TRUNC, ST_TOO_BIG};
   assign data_zero      = (rsp_item.data_size == '0) && (rsp_item.data_offset == '0);
   assign pcm_good       = (rsp_item.audio_format == PCM_FORMAT) &&
                           (rsp_item.bits_per_sample == PCM_BITS) &&
                           ((rsp_item.channels == CH_MONO) ||
                            (rsp_item.channels == CH_STEREO)) &&
                           (rsp_item.data_offset >= 32'd36);

   // Status codes stay within the defined set
   `WHP_ASSERT(a_status_range, rsp_valid |-> rsp_item.status <= ST_LAST)

   // Data fields carry values only when a data chunk was found
   `WHP_ASSERT(a_data_zero, (rsp_valid && no_data_status) |-> data_zero)

   // A good file is 16-bit PCM, mono or stereo, with its data past the headers
   `WHP_ASSERT(a_ok_format, (rsp_valid && rsp_item.status == ST_OK) |-> pcm_good)

   // A stalled response holds
   `WHP_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_item)))

endmodule

bind wav_header_parser whp_checker u_whp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_item  (rsp_ch.item)
);
